// ===== src/r2fft_pkg.sv =====
package r2fft_pkg;

  localparam int MAX_LOG2_POINTS = 6;
  localparam int SAMPLE_BITS     = 16;
  localparam int DATA_BITS       = 23;
  localparam int TW_BITS         = 16;
  localparam int Q_SHIFT         = 14;

  localparam logic signed [DATA_BITS-1:0] DATA_MAX = 23'sh3fffff;
  localparam logic signed [DATA_BITS-1:0] DATA_MIN = 23'sh400000;

  // One word in the load queue: a sample, flagged when it passes straight through.
  typedef struct packed {
    logic                        pass;
    logic signed [DATA_BITS-1:0] re;
    logic signed [DATA_BITS-1:0] im;
  } item_t;

  function automatic logic [TW_BITS-1:0] quarter_cos(input logic [4:0] k);
    logic [TW_BITS-1:0] v;
    case (k)
      5'd0:  v = 16'd16384;
      5'd1:  v = 16'd16305;
      5'd2:  v = 16'd16069;
      5'd3:  v = 16'd15679;
      5'd4:  v = 16'd15137;
      5'd5:  v = 16'd14449;
      5'd6:  v = 16'd13623;
      5'd7:  v = 16'd12665;
      5'd8:  v = 16'd11585;
      5'd9:  v = 16'd10394;
      5'd10: v = 16'd9102;
      5'd11: v = 16'd7723;
      5'd12: v = 16'd6270;
      5'd13: v = 16'd4756;
      5'd14: v = 16'd3196;
      5'd15: v = 16'd1606;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  // Twiddle for angle -2*pi*k/64, k in 0..31; returns {wr, wi}.
  function automatic logic [2*TW_BITS-1:0] twiddle(input logic [4:0] k);
    logic signed [TW_BITS-1:0] wr;
    logic signed [TW_BITS-1:0] wi;
    if (k <= 5'd16) begin
      wr = quarter_cos(k);
      wi = -$signed(quarter_cos(5'(5'd16 - k)));
    end else begin
      wr = -$signed(quarter_cos(5'(6'd32 - {1'b0, k})));
      wi = -$signed(quarter_cos(5'(k - 5'd16)));
    end
    return {wr, wi};
  endfunction

  function automatic logic signed [DATA_BITS-1:0] sat(input logic signed [DATA_BITS+1:0] x);
    logic signed [DATA_BITS-1:0] r;
    if (x > $signed({{2{1'b0}}, DATA_MAX})) r = DATA_MAX;
    else if (x < $signed({{2{1'b1}}, DATA_MIN})) r = DATA_MIN;
    else r = x[DATA_BITS-1:0];
    return r;
  endfunction

endpackage

// ===== src/radix2_fft_engine.sv =====
// Radix-2 decimation-in-time FFT over 2^log2_points complex samples (up to 64). The front
// accepts one sample per cycle into a short queue while the queue is not full; the back
// writes each sample to the sample RAM at its bit-reversed address, then runs (N/2)*log2(N)
// butterflies on one shared complex multiplier, each in the steps read a, read b, multiply,
// add and write a, write b, then reads out N bins in natural order, each through a read state
// and an output state. The back takes no samples while it transforms or unloads a frame,
// so the queue holds up to four and then stalls the input. log2_points of zero returns each
// sample as its own bin. Writing cfg_log2_points drops any partial frame.
module radix2_fft_engine #(
  parameter int MAX_LOG2_POINTS = r2fft_pkg::MAX_LOG2_POINTS,
  parameter int SAMPLE_BITS     = r2fft_pkg::SAMPLE_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_log2_points,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [SAMPLE_BITS-1:0]  in_sample_re,
  input  logic [SAMPLE_BITS-1:0]  in_sample_im,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [22:0]      out_bin_re,
  output logic signed [22:0]      out_bin_im,
  output logic [5:0]              out_bin_index,
  output logic                    out_last_bin
);

  logic [2:0]        lg_r;
  logic              q_valid, q_pop;
  r2fft_pkg::item_t  q_item;

  // Hold the transform size; a write restarts the frame.
  always_ff @(posedge clk) begin
    if (!rst_n) lg_r <= 3'd6;
    else if (cfg_we) lg_r <= cfg_log2_points;
  end

  r2fft_front #(.SAMPLE_W(SAMPLE_BITS)) u_front (
    .clk(clk), .rst_n(rst_n), .flush(cfg_we), .pass(lg_r == 3'd0),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_re(in_sample_re), .in_im(in_sample_im),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
  );

  r2fft_back #(.MAX_L(MAX_LOG2_POINTS)) u_back (
    .clk(clk), .rst_n(rst_n), .flush(cfg_we), .lg(lg_r),
    .q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_re(out_bin_re), .out_im(out_bin_im),
    .out_index(out_bin_index), .out_last(out_last_bin)
  );

endmodule

// ===== src/r2fft_ram.sv =====
module r2fft_ram #(
  parameter int WIDTH = 46,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/r2fft_front.sv =====
// Accept samples, widen (saturating if too wide), tag pass items, and push into the queue.
module r2fft_front #(
  parameter int SAMPLE_W = r2fft_pkg::SAMPLE_BITS,
  parameter int QDEPTH   = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  flush,
  input  logic                  pass,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_W-1:0]   in_re,
  input  logic [SAMPLE_W-1:0]   in_im,
  output logic                  q_valid,
  input  logic                  q_pop,
  output r2fft_pkg::item_t      q_item
);

  localparam int AW = $clog2(QDEPTH);

  r2fft_pkg::item_t     q_r [QDEPTH];
  logic [AW-1:0]        wp_r, rp_r;
  logic [AW:0]          cnt_r;
  logic                 push;
  r2fft_pkg::item_t     w;

  function automatic logic signed [r2fft_pkg::DATA_BITS-1:0] widen(input logic [SAMPLE_W-1:0] s);
    logic signed [SAMPLE_W+1:0] e;
    logic signed [r2fft_pkg::DATA_BITS-1:0] r;
    e = (SAMPLE_W+2)'($signed(s));
    if (SAMPLE_W > r2fft_pkg::DATA_BITS) begin
      if (e > (SAMPLE_W+2)'(r2fft_pkg::DATA_MAX)) r = r2fft_pkg::DATA_MAX;
      else if (e < (SAMPLE_W+2)'(r2fft_pkg::DATA_MIN)) r = r2fft_pkg::DATA_MIN;
      else r = r2fft_pkg::DATA_BITS'(e);
    end else begin
      r = r2fft_pkg::DATA_BITS'(e);
    end
    return r;
  endfunction

  assign in_stall = (cnt_r == (AW+1)'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = q_r[rp_r];

  always_comb begin
    w.pass = pass;
    w.re   = widen(in_re);
    w.im   = widen(in_im);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= w;
    end
    if (!rst_n || flush) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push)  wp_r <= wp_r + 1'b1;
      if (q_pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push) - (AW+1)'(q_pop);
    end
  end

endmodule

// ===== src/r2fft_back.sv =====
// Load a frame bit-reversed, butterfly on one shared unit, unload; pass items bypass.
module r2fft_back #(
  parameter int MAX_L = r2fft_pkg::MAX_LOG2_POINTS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 flush,
  input  logic [2:0]                           lg,
  input  logic                                 q_valid,
  output logic                                 q_pop,
  input  r2fft_pkg::item_t                     q_item,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [r2fft_pkg::DATA_BITS-1:0] out_re,
  output logic signed [r2fft_pkg::DATA_BITS-1:0] out_im,
  output logic [5:0]                           out_index,
  output logic                                 out_last
);

  localparam int DW = r2fft_pkg::DATA_BITS;
  localparam int AW = MAX_L;
  localparam int NMAX = 1 << MAX_L;
  localparam int PW = DW + r2fft_pkg::TW_BITS + 2;

  typedef enum logic [7:0] {
    S_LOAD = 8'b0000_0001,
    S_RDA  = 8'b0000_0010,
    S_RDB  = 8'b0000_0100,
    S_MUL  = 8'b0000_1000,
    S_ADD  = 8'b0001_0000,
    S_WRB  = 8'b0010_0000,
    S_RDO  = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } st_t;

  st_t             st_r;
  logic [AW:0]     cnt_r;     // load count / unload index
  logic [2:0]      stg_r;     // butterfly stage (len = 2 << stg)
  logic [AW-1:0]   bf_r;      // butterfly number within stage
  logic [2:0]      l;
  logic [AW:0]     n;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [2*DW-1:0] wdata, rdata;

  logic signed [DW-1:0] ar_r, ai_r;
  logic signed [r2fft_pkg::TW_BITS-1:0] wr_r, wi_r;
  logic signed [DW:0]   vr, vi;
  logic signed [DW-1:0] nbr_r, nbi_r;
  logic signed [PW-1:0] rr_r, ii_r, ri_r, ir_r;
  logic signed [PW-1:0] sr, si;
  logic [AW-1:0] ia, ib;
  logic [4:0]    tk;

  assign l = (lg > 3'(MAX_L)) ? 3'(MAX_L) : lg;
  assign n = (AW+1)'(1) << l;

  // Address of butterfly bf in current stage.
  always_comb begin
    logic [AW-1:0] half, k, grp;
    half = AW'(1) << stg_r;
    k    = bf_r & (half - 1'b1);
    grp  = (bf_r >> stg_r) << (stg_r + 3'd1);
    ia   = grp | k;
    ib   = ia | half;
    tk   = 5'(11'(k) << (3'd5 - stg_r));
  end

  function automatic logic [AW-1:0] brev(input logic [AW-1:0] i, input logic [2:0] b);
    logic [AW-1:0] r;
    r = '0;
    for (int j = 0; j < AW; j++) begin
      if (3'(j) < b) r[b - 3'd1 - 3'(j)] = i[j];
    end
    return r;
  endfunction

  r2fft_ram #(.WIDTH(2*DW), .DEPTH(NMAX)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  assign q_pop = (st_r == S_LOAD) && q_valid && !(q_item.pass && out_valid && out_stall);

  always_comb begin
    we    = 1'b0;
    waddr = ia;
    wdata = {nbr_r, nbi_r};
    raddr = ia;
    unique case (st_r)
      S_LOAD: begin
        we    = q_pop && !q_item.pass;
        waddr = brev(cnt_r[AW-1:0], l);
        wdata = {q_item.re, q_item.im};
      end
      S_RDA:  raddr = ia;
      S_RDB:  raddr = ib;
      S_MUL:  raddr = ib;
      S_ADD: begin
        we    = 1'b1;
        waddr = ia;
        wdata = {r2fft_pkg::sat((DW+2)'(ar_r) + (DW+2)'(vr)),
                 r2fft_pkg::sat((DW+2)'(ai_r) + (DW+2)'(vi))};
      end
      S_WRB: begin
        we    = 1'b1;
        waddr = ib;
      end
      S_RDO:  raddr = cnt_r[AW-1:0];
      S_OUT:  raddr = cnt_r[AW-1:0];
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    // Hold sample a across read latency with its twiddle; register the b result.
    if (st_r == S_RDB) begin
      ar_r <= rdata[2*DW-1:DW];
      ai_r <= rdata[DW-1:0];
      {wr_r, wi_r} <= r2fft_pkg::twiddle(tk);
    end
    if (st_r == S_ADD) begin
      nbr_r <= r2fft_pkg::sat((DW+2)'(ar_r) - (DW+2)'(vr));
      nbi_r <= r2fft_pkg::sat((DW+2)'(ai_r) - (DW+2)'(vi));
    end
  end

  // Complex product with round-to-nearest, ties up.
  always_ff @(posedge clk) begin
    if (st_r == S_MUL) begin
      rr_r <= $signed(rdata[2*DW-1:DW]) * wr_r;
      ii_r <= $signed(rdata[DW-1:0]) * wi_r;
      ri_r <= $signed(rdata[2*DW-1:DW]) * wi_r;
      ir_r <= $signed(rdata[DW-1:0]) * wr_r;
    end
  end
  assign sr = rr_r - ii_r + PW'(8192);
  assign si = ri_r + ir_r + PW'(8192);
  always_comb begin
    vr = (DW+1)'(sr >>> r2fft_pkg::Q_SHIFT);
    vi = (DW+1)'(si >>> r2fft_pkg::Q_SHIFT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      st_r      <= S_LOAD;
      cnt_r     <= '0;
      stg_r     <= '0;
      bf_r      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      unique case (st_r)
        S_LOAD: begin
          if (q_pop) begin
            if (q_item.pass) begin
              out_valid <= 1'b1;
              out_re    <= q_item.re;
              out_im    <= q_item.im;
              out_index <= '0;
              out_last  <= 1'b1;
              cnt_r     <= '0;
            end else if (cnt_r + 1'b1 == n) begin
              cnt_r <= '0;
              stg_r <= '0;
              bf_r  <= '0;
              st_r  <= S_RDA;
            end else begin
              cnt_r <= cnt_r + 1'b1;
            end
          end
        end
        S_RDA: st_r <= S_RDB;
        S_RDB: st_r <= S_MUL;
        S_MUL: st_r <= S_ADD;
        S_ADD: st_r <= S_WRB;
        S_WRB: begin
          if ((AW+1)'(bf_r) + 1'b1 == (n >> 1)) begin
            bf_r <= '0;
            if (stg_r + 3'd1 == l) st_r <= S_RDO;
            else begin
              stg_r <= stg_r + 3'd1;
              st_r  <= S_RDA;
            end
          end else begin
            bf_r <= bf_r + 1'b1;
            st_r <= S_RDA;
          end
        end
        S_RDO: st_r <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            out_re    <= rdata[2*DW-1:DW];
            out_im    <= rdata[DW-1:0];
            out_index <= 6'(cnt_r);
            out_last  <= (cnt_r + 1'b1 == n);
            if (cnt_r + 1'b1 == n) begin
              cnt_r <= '0;
              st_r  <= S_LOAD;
            end else begin
              cnt_r <= cnt_r + 1'b1;
              st_r  <= S_RDO;
            end
          end
        end
        default: st_r <= S_LOAD;
      endcase
    end
  end

endmodule

// ===== src/r2fft_checker.sv =====
module r2fft_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [5:0]  out_bin_index,
  input logic        out_last_bin,
  input logic        in_valid,
  input logic        in_stall
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_bin_index))
    else $error("stalled result changed");

  a_next: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_bin |=> !out_valid ||
      out_bin_index != $past(out_bin_index))
    else $error("bin repeated");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    $past(out_valid && !out_stall && out_last_bin) && out_valid && !out_last_bin
      |-> out_bin_index == 6'd0)
    else $error("frame not started at bin zero");

endmodule

bind radix2_fft_engine r2fft_checker u_chk (.*);

// ===== dv/radix2_fft_checker.sv =====
module radix2_fft_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_log2_points,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_sample_re,
  input  logic [15:0] in_sample_im,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [22:0] out_bin_re,
  input  logic [22:0] out_bin_im,
  input  logic [5:0]  out_bin_index,
  input  logic        out_last_bin,
  output int          fail_count,
  output int          bins_pending,
  output int          bins_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUARTER_COS [17] = '{16384, 16305, 16069, 15679, 15137, 14449, 13623,
    12665, 11585, 10394, 9102, 7723, 6270, 4756, 3196, 1606, 0};

  typedef struct {
    logic [22:0] re;
    logic [22:0] im;
    logic [5:0]  idx;
    logic        last;
  } bin_t;

  bin_t        bin_queue[$];
  longint      frame_re [64];
  longint      frame_im [64];
  int unsigned loaded;
  logic [2:0]  size_reg;

  function automatic longint clip23(input longint x);
    if (x > 4194303) return 4194303;
    if (x < -4194304) return -4194304;
    return x;
  endfunction

  // Round to nearest with ties up, then drop the 14 fraction bits.
  function automatic longint scale_q14(input longint x);
    return (x + 8192) >>> 14;
  endfunction

  task automatic run_fft(input int lg);
    int n, j, len, half, step, k, a, b, wr, wi, tw;
    longint t, vr, vi, ur, ui;
    n = 1 << lg;
    for (int i = 0; i < n; i++) begin
      j = 0;
      for (int q = 0; q < lg; q++) j = (j << 1) | ((i >> q) & 1);
      if (i < j) begin
        t = frame_re[i]; frame_re[i] = frame_re[j]; frame_re[j] = t;
        t = frame_im[i]; frame_im[i] = frame_im[j]; frame_im[j] = t;
      end
    end
    for (len = 2; len <= n; len = len << 1) begin
      half = len >> 1;
      step = 64 / len;
      for (int i = 0; i < n; i += len) begin
        for (k = 0; k < half; k++) begin
          a = i + k;
          b = a + half;
          tw = (k * step) & 31;
          if (tw <= 16) begin
            wr = QUARTER_COS[tw]; wi = -QUARTER_COS[16 - tw];
          end else begin
            wr = -QUARTER_COS[32 - tw]; wi = -QUARTER_COS[tw - 16];
          end
          vr = scale_q14(frame_re[b] * wr - frame_im[b] * wi);
          vi = scale_q14(frame_re[b] * wi + frame_im[b] * wr);
          ur = frame_re[a];
          ui = frame_im[a];
          frame_re[a] = clip23(ur + vr);
          frame_im[a] = clip23(ui + vi);
          frame_re[b] = clip23(ur - vr);
          frame_im[b] = clip23(ui - vi);
        end
      end
    end
  endtask

  // Track each sample transfer and queue a frame's bins once it is complete.
  task automatic load_sample(input logic [15:0] sre, input logic [15:0] sim);
    int lg, n;
    bin_t b;
    lg = (size_reg > 6) ? 6 : size_reg;
    n = 1 << lg;
    if (lg == 0) begin
      b.re = 23'($signed(sre)); b.im = 23'($signed(sim)); b.idx = '0; b.last = 1'b1;
      bin_queue.push_back(b);
      loaded = 0;
      return;
    end
    if (loaded >= n) loaded = 0;
    frame_re[loaded] = longint'($signed(sre));
    frame_im[loaded] = longint'($signed(sim));
    loaded++;
    if (loaded < n) return;
    run_fft(lg);
    for (int k = 0; k < n; k++) begin
      b.re = 23'(frame_re[k]); b.im = 23'(frame_im[k]);
      b.idx = 6'(k); b.last = (k == n - 1);
      bin_queue.push_back(b);
    end
    loaded = 0;
  endtask

  always @(posedge clk) begin
    bin_t e;
    if (!rst_n) begin
      size_reg <= 3'd6;
      loaded = 0;
    end else begin
      if (cfg_we) begin
        size_reg <= cfg_log2_points;
        loaded = 0;
      end
      if (in_valid && !in_stall) load_sample(in_sample_re, in_sample_im);
      if (out_valid && !out_stall) begin
        bins_seen++;
        if (bin_queue.size() == 0) begin
          $error("unexpected bin %0d", out_bin_index);
          fail_count++;
        end else begin
          e = bin_queue.pop_front();
          if (out_bin_re !== e.re) begin
            $error("bin_re: expected %0d, got %0d", $signed(e.re), $signed(out_bin_re));
            fail_count++;
          end
          if (out_bin_im !== e.im) begin
            $error("bin_im: expected %0d, got %0d", $signed(e.im), $signed(out_bin_im));
            fail_count++;
          end
          if (out_bin_index !== e.idx) begin
            $error("bin_index: expected %0d, got %0d", e.idx, out_bin_index);
            fail_count++;
          end
          if (out_last_bin !== e.last) begin
            $error("last_bin: expected %0d, got %0d", e.last, out_last_bin);
            fail_count++;
          end
        end
      end
    end
    bins_pending = bin_queue.size();
  end

  initial begin
    fail_count = 0;
    bins_pending = 0;
    bins_seen = 0;
  end
endmodule

// ===== dv/radix2_fft_engine_tb.sv =====
module radix2_fft_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_log2_points;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_sample_re;
  logic [15:0] in_sample_im;
  logic        out_valid;
  logic        out_stall;
  logic [22:0] out_bin_re;
  logic [22:0] out_bin_im;
  logic [5:0]  out_bin_index;
  logic        out_last_bin;
  int          fail_count;
  int          bins_pending;
  int          bins_seen;
  int          samples_sent;
  bit          idle_enable;

  radix2_fft_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_log2_points(cfg_log2_points),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_re   (in_sample_re),
    .in_sample_im   (in_sample_im),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bin_re     (out_bin_re),
    .out_bin_im     (out_bin_im),
    .out_bin_index  (out_bin_index),
    .out_last_bin   (out_last_bin)
  );

  radix2_fft_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_log2_points(cfg_log2_points),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_sample_re   (in_sample_re),
    .in_sample_im   (in_sample_im),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_bin_re     (out_bin_re),
    .out_bin_im     (out_bin_im),
    .out_bin_index  (out_bin_index),
    .out_last_bin   (out_last_bin),
    .fail_count     (fail_count),
    .bins_pending   (bins_pending),
    .bins_seen      (bins_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall in random bursts while idling is enabled.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_enable && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hold one sample on the port until it transfers, with an optional gap first.
  task automatic send_sample(input logic [15:0] sre, input logic [15:0] sim);
    if (idle_enable && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_re <= sre;
    in_sample_im <= sim;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    samples_sent++;
  endtask

  // Drain all bins, let the engine settle, then write the size register.
  task automatic set_size(input logic [2:0] lg);
    in_valid <= 1'b0;
    while (bins_pending != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
    cfg_log2_points <= lg;
    cfg_we          <= 1'b1;
    @(negedge clk);
    cfg_we          <= 1'b0;
  endtask

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int lg;
    idle_enable     = 1'b0;
    samples_sent    = 0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_log2_points = 3'd6;
    in_valid        = 1'b0;
    in_sample_re    = '0;
    in_sample_im    = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // Directed: pass-through extremes, 2- and 4-point frames each with a stray
    // sample the next write drops, and a full-scale 64-point frame at size 7.
    set_size(3'd0);
    send_sample(16'h7fff, 16'h8000);
    send_sample(16'h8000, 16'h7fff);
    send_sample(16'h0000, 16'hffff);
    set_size(3'd1);
    send_sample(16'h7fff, 16'h7fff);
    send_sample(16'h8000, 16'h8000);
    send_sample(16'h1234, 16'h5555);
    set_size(3'd2);
    for (int i = 0; i < 4; i++) send_sample(16'h8000, 16'h7fff);
    send_sample(16'h0001, 16'h0002);
    set_size(3'd7);
    for (int i = 0; i < 64; i++) send_sample(16'h7fff, 16'h7fff);

    // Random frames: mostly small sizes, a few full 64-point frames.
    idle_enable = 1'b1;
    while (samples_sent < 330) begin
      if (samples_sent > 270) idle_enable = 1'b0;
      lg = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
      set_size(3'(lg));
      for (int f = 0; f < $urandom_range(1, 3); f++) begin
        for (int i = 0; i < (1 << (lg > 6 ? 6 : lg)); i++)
          send_sample(rand_sample(), rand_sample());
        // A stray sample shifts the frames; the next write drops any partial.
        if ($urandom_range(0, 7) == 0 && lg > 1) send_sample(rand_sample(), rand_sample());
      end
    end
    in_valid <= 1'b0;

    while (bins_pending != 0) @(negedge clk);
    repeat (1200) @(negedge clk);
    $display("Sent %0d samples over sizes 1 to 64 points and pass-through; checked %0d bins.",
             samples_sent, bins_seen);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb: failure");
    $finish;
  end
endmodule

// ===== files.f =====
src/r2fft_pkg.sv
src/r2fft_ram.sv
src/r2fft_front.sv
src/r2fft_back.sv
src/radix2_fft_engine.sv
src/r2fft_checker.sv
dv/radix2_fft_checker.sv
dv/radix2_fft_engine_tb.sv
